// ----- rtl/csr_adjacency_build_assert.svh -----
// ----------------------------------------------------------------------------
// csr_adjacency_build assertion macros
// Shared concurrent assertion forms, clocked on clk, held off in reset.
// ----------------------------------------------------------------------------
`ifndef CSR_ADJACENCY_BUILD_ASSERT_SVH
`define CSR_ADJACENCY_BUILD_ASSERT_SVH

// property must hold at every edge out of reset
`define CAB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition must never be seen
`define CAB_NEVER(lbl, cond, msg) \
	`CAB_ASSERT(lbl, !(cond), msg)

`endif

// ----- rtl/cab_pkg.sv -----
// ----------------------------------------------------------------------------
// cab_pkg
// Widths, codes and shared types for the CSR adjacency builder.
// ----------------------------------------------------------------------------
package cab_pkg;

	localparam int MAX_NODES = 1024;
	localparam int MAX_EDGES = 4096;

	localparam int NODE_W = 10;  // node ID
	localparam int NCNT_W = 11;  // node count, offset index
	localparam int EIDX_W = 12;  // edge store index
	localparam int ECNT_W = 13;  // edge count
	localparam int AIDX_W = 13;  // adjacency index
	localparam int VAL_W  = 14;  // offsets, degrees

	localparam logic [1:0] CMD_LOAD     = 2'd0;
	localparam logic [1:0] CMD_RD_OFS   = 2'd1;
	localparam logic [1:0] CMD_RD_NBR   = 2'd2;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NOT_BUILT = 3'd1;
	localparam logic [2:0] ST_BAD_INDEX = 3'd2;
	localparam logic [2:0] ST_FULL      = 3'd3;
	localparam logic [2:0] ST_BAD_NODE  = 3'd4;

	localparam logic REG_MODE  = 1'b0;
	localparam logic REG_NODES = 1'b1;

	typedef struct packed {
		logic [EIDX_W-1:0] edge_ra;
		logic              off_we;
		logic [NCNT_W-1:0] off_wa;
		logic [VAL_W-1:0]  off_wd;
		logic [NCNT_W-1:0] off_ra;
		logic              adj_we;
		logic [AIDX_W-1:0] adj_wa;
		logic [NODE_W-1:0] adj_wd;
	} seq_req_t;

	typedef struct packed {
		logic              done;
		logic [NCNT_W-1:0] nodes;
		logic [VAL_W-1:0]  total;
	} seq_done_t;

endpackage

// ----- rtl/cab_ram.sv -----
// ----------------------------------------------------------------------------
// cab_ram
// Single write port, single read port synchronous RAM, registered read.
// ----------------------------------------------------------------------------
module cab_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wa,
	input  logic [WIDTH-1:0]         wd,
	input  logic [$clog2(DEPTH)-1:0] ra,
	output logic [WIDTH-1:0]         rd
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd <= mem[ra];
	end

endmodule

// ----- rtl/cab_seq.sv -----
// ----------------------------------------------------------------------------
// cab_seq
// Build sequencer: clears degrees, counts, forms offsets, scatters neighbours.
// ----------------------------------------------------------------------------
module cab_seq (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        go,
	input  logic [cab_pkg::NCNT_W-1:0]  go_nodes,
	input  logic                        go_both,
	input  logic [cab_pkg::ECNT_W-1:0]  go_edges,
	input  logic [2*cab_pkg::NODE_W-1:0] edge_rd,
	input  logic [cab_pkg::VAL_W-1:0]   off_rd,
	output logic                        busy,
	output cab_pkg::seq_req_t           req,
	output cab_pkg::seq_done_t          fin
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_CLR  = 4'd1;
	localparam logic [3:0] S_ERD  = 4'd2;
	localparam logic [3:0] S_ESRC = 4'd3;
	localparam logic [3:0] S_ESW  = 4'd4;
	localparam logic [3:0] S_ETR  = 4'd5;
	localparam logic [3:0] S_ETW  = 4'd6;
	localparam logic [3:0] S_ORD  = 4'd7;
	localparam logic [3:0] S_OWR  = 4'd8;
	localparam logic [3:0] S_SRD  = 4'd9;
	localparam logic [3:0] S_SU   = 4'd10;
	localparam logic [3:0] S_SUW  = 4'd11;
	localparam logic [3:0] S_SV   = 4'd12;
	localparam logic [3:0] S_SVW  = 4'd13;

	logic [3:0]                      state_q;
	logic [cab_pkg::ECNT_W-1:0]      i_q;
	logic [cab_pkg::VAL_W-1:0]       acc_q;
	logic [cab_pkg::NCNT_W-1:0]      n_q;
	logic                            both_q;
	logic [cab_pkg::ECNT_W-1:0]      ecnt_q;
	logic [cab_pkg::NODE_W-1:0]      u_q;
	logic [cab_pkg::NODE_W-1:0]      v_q;

	logic                            deg_we;
	logic [cab_pkg::NODE_W-1:0]      deg_wa;
	logic [cab_pkg::VAL_W-1:0]       deg_wd;
	logic [cab_pkg::NODE_W-1:0]      deg_ra;
	logic [cab_pkg::VAL_W-1:0]       deg_rd;
	logic [cab_pkg::VAL_W-1:0]       acc_nx;
	logic                            node_more;
	logic                            edge_more;

	cab_ram #(.DEPTH(cab_pkg::MAX_NODES), .WIDTH(cab_pkg::VAL_W)) u_deg (
		.clk (clk),
		.we  (deg_we),
		.wa  (deg_wa),
		.wd  (deg_wd),
		.ra  (deg_ra),
		.rd  (deg_rd)
	);

	assign node_more = i_q < {{(cab_pkg::ECNT_W-cab_pkg::NCNT_W){1'b0}}, n_q};
	assign edge_more = i_q < ecnt_q;
	assign acc_nx    = acc_q + deg_rd;
	// held through the cycle in which the finished build is handed over
	assign busy      = state_q != S_IDLE || fin.done;

	always_comb begin
		deg_we      = 1'b0;
		deg_wa      = i_q[cab_pkg::NODE_W-1:0];
		deg_wd      = '0;
		deg_ra      = i_q[cab_pkg::NODE_W-1:0];
		req         = '0;
		req.edge_ra = i_q[cab_pkg::EIDX_W-1:0];
		req.adj_wa  = off_rd[cab_pkg::AIDX_W-1:0] + deg_rd[cab_pkg::AIDX_W-1:0];
		case (state_q)
			S_CLR: begin
				deg_we = node_more;
			end
			S_ERD: begin
				req.off_we = !edge_more;
			end
			S_ESRC: begin
				deg_ra = edge_rd[2*cab_pkg::NODE_W-1:cab_pkg::NODE_W];
			end
			S_ESW: begin
				deg_we = 1'b1;
				deg_wa = u_q;
				deg_wd = deg_rd + 1'b1;
			end
			S_ETR: begin
				deg_ra = v_q;
			end
			S_ETW: begin
				deg_we = 1'b1;
				deg_wa = v_q;
				deg_wd = deg_rd + 1'b1;
			end
			S_OWR: begin
				deg_we     = 1'b1;
				req.off_we = 1'b1;
				req.off_wa = i_q[cab_pkg::NCNT_W-1:0] + 1'b1;
				req.off_wd = acc_nx;
			end
			S_SU: begin
				deg_ra     = edge_rd[2*cab_pkg::NODE_W-1:cab_pkg::NODE_W];
				req.off_ra = {1'b0, edge_rd[2*cab_pkg::NODE_W-1:cab_pkg::NODE_W]};
			end
			S_SUW: begin
				deg_we     = 1'b1;
				deg_wa     = u_q;
				deg_wd     = deg_rd + 1'b1;
				req.adj_we = 1'b1;
				req.adj_wd = v_q;
			end
			S_SV: begin
				deg_ra     = v_q;
				req.off_ra = {1'b0, v_q};
			end
			S_SVW: begin
				deg_we     = 1'b1;
				deg_wa     = v_q;
				deg_wd     = deg_rd + 1'b1;
				req.adj_we = 1'b1;
				req.adj_wd = u_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			i_q     <= '0;
			acc_q   <= '0;
			n_q     <= '0;
			both_q  <= 1'b0;
			ecnt_q  <= '0;
			fin     <= '0;
		end else begin
			fin.done <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (go) begin
						n_q     <= go_nodes;
						both_q  <= go_both;
						ecnt_q  <= go_edges;
						i_q     <= '0;
						state_q <= S_CLR;
					end
				end
				S_CLR: begin
					if (node_more) begin
						i_q <= i_q + 1'b1;
					end else begin
						i_q     <= '0;
						state_q <= S_ERD;
					end
				end
				S_ERD: begin
					if (edge_more) begin
						state_q <= S_ESRC;
					end else begin
						i_q     <= '0;
						acc_q   <= '0;
						state_q <= S_ORD;
					end
				end
				S_ESRC: state_q <= S_ESW;
				S_ESW: begin
					if (both_q) begin
						state_q <= S_ETR;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= S_ERD;
					end
				end
				S_ETR: state_q <= S_ETW;
				S_ETW: begin
					i_q     <= i_q + 1'b1;
					state_q <= S_ERD;
				end
				S_ORD: begin
					if (node_more) begin
						state_q <= S_OWR;
					end else begin
						i_q     <= '0;
						state_q <= S_SRD;
					end
				end
				S_OWR: begin
					acc_q   <= acc_nx;
					i_q     <= i_q + 1'b1;
					state_q <= S_ORD;
				end
				S_SRD: begin
					if (edge_more) begin
						state_q <= S_SU;
					end else begin
						fin.done  <= 1'b1;
						fin.nodes <= n_q;
						fin.total <= acc_q;
						state_q   <= S_IDLE;
					end
				end
				S_SU: state_q <= S_SUW;
				S_SUW: begin
					if (both_q) begin
						state_q <= S_SV;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= S_SRD;
					end
				end
				S_SV: state_q <= S_SVW;
				S_SVW: begin
					i_q     <= i_q + 1'b1;
					state_q <= S_SRD;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// edge endpoints captured from the edge RAM read data in S_ESRC and S_SU
	always_ff @(posedge clk) begin
		if (state_q == S_ESRC || state_q == S_SU) begin
			u_q <= edge_rd[2*cab_pkg::NODE_W-1:cab_pkg::NODE_W];
			v_q <= edge_rd[cab_pkg::NODE_W-1:0];
		end
	end

endmodule

// ----- rtl/csr_adjacency_build.sv -----
// ----------------------------------------------------------------------------
// csr_adjacency_build
// Edge loader, CSR builder and offset / neighbour reader.
// ----------------------------------------------------------------------------
// channel   | handshake            | beat
// ----------+----------------------+--------------------------------------
// command   | start && !busy       | command, source_node, target_node, last_edge, read_index
// result    | done                 | read_value, status
// config    | psel&penable&pwrite  | paddr, pwdata
//
// The result strobes the cycle after accept. A load marked last then runs
// the build, busy high while it runs, bound by the single degree RAM port.
// Reset clears control state only; the stores need no clearing pass.
// The receiver cannot stall the result.
// ----------------------------------------------------------------------------
module csr_adjacency_build (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  command,
	input  logic [9:0]  source_node,
	input  logic [9:0]  target_node,
	input  logic        last_edge,
	input  logic [12:0] read_index,
	output logic        done,
	output logic [13:0] read_value,
	output logic [2:0]  status,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic                            mode_q;
	logic [cab_pkg::NCNT_W-1:0]      nodes_q;
	logic [cab_pkg::ECNT_W-1:0]      ecnt_q;
	logic                            built_q;
	logic [cab_pkg::NCNT_W-1:0]      bnodes_q;
	logic [cab_pkg::VAL_W-1:0]       total_q;

	logic                            accept;
	logic [cab_pkg::NCNT_W-1:0]      live_n;
	logic [cab_pkg::ECNT_W-1:0]      eff_cnt;
	logic [cab_pkg::ECNT_W-1:0]      new_cnt;
	logic                            edge_we;
	logic [2:0]                      st_d;
	logic                            seq_busy;
	cab_pkg::seq_req_t               req;
	cab_pkg::seq_done_t              fin;
	logic [2*cab_pkg::NODE_W-1:0]    edge_rd;
	logic [cab_pkg::VAL_W-1:0]       off_rd;
	logic [cab_pkg::NODE_W-1:0]      adj_rd;
	logic [cab_pkg::NCNT_W-1:0]      off_ra;

	logic                            vld_s1;
	logic [2:0]                      st_s1;
	logic                            ofs_s1;
	logic                            nbr_s1;

	assign pready = 1'b1;
	assign busy   = seq_busy;
	assign accept = start && !seq_busy;

	assign live_n  = (nodes_q > cab_pkg::NCNT_W'(cab_pkg::MAX_NODES)) ?
		cab_pkg::NCNT_W'(cab_pkg::MAX_NODES) : nodes_q;
	assign eff_cnt = built_q ? '0 : ecnt_q;

	always_comb begin
		st_d    = cab_pkg::ST_OK;
		edge_we = 1'b0;
		new_cnt = eff_cnt;
		case (command)
			cab_pkg::CMD_LOAD: begin
				if (eff_cnt == cab_pkg::ECNT_W'(cab_pkg::MAX_EDGES)) begin
					st_d = cab_pkg::ST_FULL;
				end else if ({1'b0, source_node} >= live_n ||
						{1'b0, target_node} >= live_n) begin
					st_d = cab_pkg::ST_BAD_NODE;
				end else begin
					edge_we = accept;
					new_cnt = eff_cnt + 1'b1;
				end
			end
			cab_pkg::CMD_RD_OFS: begin
				if (!built_q) begin
					st_d = cab_pkg::ST_NOT_BUILT;
				end else if (read_index > {2'b0, bnodes_q}) begin
					st_d = cab_pkg::ST_BAD_INDEX;
				end
			end
			cab_pkg::CMD_RD_NBR: begin
				if (!built_q) begin
					st_d = cab_pkg::ST_NOT_BUILT;
				end else if ({1'b0, read_index} >= total_q) begin
					st_d = cab_pkg::ST_BAD_INDEX;
				end
			end
			default: st_d = cab_pkg::ST_BAD_INDEX;
		endcase
	end

	assign off_ra = seq_busy ? req.off_ra : read_index[cab_pkg::NCNT_W-1:0];

	cab_ram #(.DEPTH(cab_pkg::MAX_EDGES), .WIDTH(2*cab_pkg::NODE_W)) u_edge (
		.clk (clk),
		.we  (edge_we),
		.wa  (eff_cnt[cab_pkg::EIDX_W-1:0]),
		.wd  ({source_node, target_node}),
		.ra  (req.edge_ra),
		.rd  (edge_rd)
	);

	cab_ram #(.DEPTH(cab_pkg::MAX_NODES + 1), .WIDTH(cab_pkg::VAL_W)) u_off (
		.clk (clk),
		.we  (req.off_we),
		.wa  (req.off_wa),
		.wd  (req.off_wd),
		.ra  (off_ra),
		.rd  (off_rd)
	);

	cab_ram #(.DEPTH(2*cab_pkg::MAX_EDGES), .WIDTH(cab_pkg::NODE_W)) u_adj (
		.clk (clk),
		.we  (req.adj_we),
		.wa  (req.adj_wa),
		.wd  (req.adj_wd),
		.ra  (read_index[cab_pkg::AIDX_W-1:0]),
		.rd  (adj_rd)
	);

	cab_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (accept && command == cab_pkg::CMD_LOAD && last_edge),
		.go_nodes (live_n),
		.go_both  (!mode_q),
		.go_edges (new_cnt),
		.edge_rd  (edge_rd),
		.off_rd   (off_rd),
		.busy     (seq_busy),
		.req      (req),
		.fin      (fin)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b0;
			nodes_q  <= cab_pkg::NCNT_W'(cab_pkg::MAX_NODES);
			ecnt_q   <= '0;
			built_q  <= 1'b0;
			bnodes_q <= '0;
			total_q  <= '0;
			vld_s1   <= 1'b0;
		end else begin
			if (psel && penable && pwrite) begin
				if (paddr[2] == cab_pkg::REG_MODE) begin
					mode_q <= pwdata[0];
				end else begin
					nodes_q <= pwdata[cab_pkg::NCNT_W-1:0];
				end
			end
			vld_s1 <= accept;
			if (accept && command == cab_pkg::CMD_LOAD) begin
				ecnt_q  <= new_cnt;
				built_q <= 1'b0;
			end
			if (fin.done) begin
				built_q  <= 1'b1;
				bnodes_q <= fin.nodes;
				total_q  <= fin.total;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			st_s1  <= st_d;
			ofs_s1 <= command == cab_pkg::CMD_RD_OFS;
			nbr_s1 <= command == cab_pkg::CMD_RD_NBR;
		end
	end

	// loads and refused reads return zero
	always_comb begin
		read_value = '0;
		if (st_s1 == cab_pkg::ST_OK) begin
			if (ofs_s1) begin
				read_value = off_rd;
			end else if (nbr_s1) begin
				read_value = {4'b0, adj_rd};
			end
		end
	end

	assign done   = vld_s1;
	assign status = st_s1;
	assign prdata = (paddr[2] == cab_pkg::REG_MODE) ? {31'b0, mode_q} :
		{21'b0, nodes_q};

	`include "csr_adjacency_build_assert.svh"

	`CAB_ASSERT(a_one_result, done == $past(start && !busy), "result not one cycle after accept")
	`CAB_NEVER(a_built_busy, built_q && seq_busy, "graph marked built while building")
	`CAB_NEVER(a_edge_cnt, ecnt_q > cab_pkg::ECNT_W'(cab_pkg::MAX_EDGES), "edge count overflow")
	`CAB_NEVER(a_total, built_q && total_q > cab_pkg::VAL_W'(2*cab_pkg::MAX_EDGES), "entry total overflow")

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for csr_adjacency_build. Edge lists are loaded, built
// and read back under many mode and node count settings, including an empty
// build, rejected edges and a completely full edge store. A local graph
// builder predicts every result beat, which the monitor compares in order.
// ----------------------------------------------------------------------------
module tb;

	localparam logic [1:0] CMD_UNKNOWN = 2'd3;
	localparam int LIMIT = 4000000;

	typedef struct {
		bit          is_cfg;
		bit          drain;
		logic [1:0]  cmd;
		logic [9:0]  src;
		logic [9:0]  tgt;
		logic        last;
		logic [12:0] idx;
		logic        reg_sel;
		logic [31:0] data;
	} item_t;

	typedef struct {
		logic [13:0] value;
		logic [2:0]  st;
	} beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  command = cab_pkg::CMD_LOAD;
	logic [9:0]  source_node = '0;
	logic [9:0]  target_node = '0;
	logic        last_edge = 1'b0;
	logic [12:0] read_index = '0;
	logic        done;
	logic [13:0] read_value;
	logic [2:0]  status;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	csr_adjacency_build DUT (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	item_t pend_q[$];
	beat_t csr_expect_q[$];
	int    errors = 0;
	int    n_loads = 0, n_reads = 0, n_builds = 0, n_beats = 0;
	int    cycles = 0;

	// graph builder state
	logic        g_directed = 1'b0;
	int          g_nodes = 1024;
	logic [9:0]  g_esrc[cab_pkg::MAX_EDGES];
	logic [9:0]  g_etgt[cab_pkg::MAX_EDGES];
	int          g_deg[cab_pkg::MAX_NODES];
	int          g_ofs[cab_pkg::MAX_NODES+1];
	logic [9:0]  g_adj[2*cab_pkg::MAX_EDGES];
	int          g_loaded = 0;
	bit          g_built = 0;
	int          g_built_nodes = 0;

	function automatic int live_nodes();
		return g_nodes > cab_pkg::MAX_NODES ? cab_pkg::MAX_NODES : g_nodes;
	endfunction

	function automatic void build_csr();
		int n;
		int u, v;
		bit both;
		n = live_nodes();
		both = !g_directed;
		for (int i = 0; i < n; i++) g_deg[i] = 0;
		for (int i = 0; i < g_loaded; i++) begin
			g_deg[g_esrc[i]]++;
			if (both) g_deg[g_etgt[i]]++;
		end
		g_ofs[0] = 0;
		for (int i = 0; i < n; i++) begin
			g_ofs[i+1] = g_ofs[i] + g_deg[i];
			g_deg[i] = 0;
		end
		for (int i = 0; i < g_loaded; i++) begin
			u = g_esrc[i];
			v = g_etgt[i];
			g_adj[g_ofs[u] + g_deg[u]] = v;
			g_deg[u]++;
			if (both) begin
				g_adj[g_ofs[v] + g_deg[v]] = u;
				g_deg[v]++;
			end
		end
		g_built_nodes = n;
		g_built = 1;
		n_builds++;
	endfunction

	function automatic void predict_beat(item_t it);
		beat_t b;
		int n;
		b.value = '0;
		b.st = cab_pkg::ST_OK;
		if (it.cmd == cab_pkg::CMD_LOAD) begin
			n_loads++;
			n = live_nodes();
			if (g_built) begin
				g_loaded = 0;
				g_built = 0;
			end
			if (g_loaded >= cab_pkg::MAX_EDGES) b.st = cab_pkg::ST_FULL;
			else if (it.src >= n || it.tgt >= n) b.st = cab_pkg::ST_BAD_NODE;
			else begin
				g_esrc[g_loaded] = it.src;
				g_etgt[g_loaded] = it.tgt;
				g_loaded++;
			end
			if (it.last) build_csr();
		end else if (it.cmd == CMD_UNKNOWN) begin
			b.st = cab_pkg::ST_BAD_INDEX;
		end else begin
			n_reads++;
			if (!g_built) b.st = cab_pkg::ST_NOT_BUILT;
			else if (it.cmd == cab_pkg::CMD_RD_OFS) begin
				if (it.idx > g_built_nodes) b.st = cab_pkg::ST_BAD_INDEX;
				else b.value = g_ofs[it.idx];
			end else begin
				if (it.idx >= g_ofs[g_built_nodes]) b.st = cab_pkg::ST_BAD_INDEX;
				else b.value = g_adj[it.idx];
			end
		end
		csr_expect_q.push_back(b);
	endfunction

	task automatic report(string what, logic [13:0] got, logic [13:0] want);
		errors++;
		$display("MISMATCH beat %0d %s: got %0d want %0d", n_beats, what, got, want);
	endtask

	// driver
	item_t cur, cfg_cur;
	int    gap = 0, burst = 0, quiet = 0, apb_ph = 0;

	function automatic int draw_gap();
		if (burst > 0) begin
			burst--;
			return 0;
		end
		if ($urandom_range(0, 30) == 0) burst = $urandom_range(10, 60);
		return $urandom_range(0, 11);
	endfunction

	always @(posedge clk) begin : drive
		logic go;
		item_t it;
		if (arst_n) begin
			go = start;
			if (start && !busy) begin
				predict_beat(cur);
				go = 1'b0;
			end
			if (!busy && !start && !psel && csr_expect_q.size() == 0) quiet++;
			else quiet = 0;
			if (apb_ph == 1) begin
				penable <= 1'b1;
				apb_ph = 2;
			end else if (apb_ph == 2) begin
				psel <= 1'b0;
				penable <= 1'b0;
				pwrite <= 1'b0;
				if (cfg_cur.reg_sel == cab_pkg::REG_MODE) g_directed = cfg_cur.data[0];
				else g_nodes = cfg_cur.data[10:0];
				apb_ph = 0;
				gap = draw_gap();
			end else if (!go) begin
				if (gap > 0) gap--;
				else if (pend_q.size() > 0) begin
					it = pend_q[0];
					if (it.is_cfg) begin
						if (quiet >= 4) begin
							void'(pend_q.pop_front());
							cfg_cur = it;
							psel <= 1'b1;
							pwrite <= 1'b1;
							paddr <= (it.reg_sel == cab_pkg::REG_MODE) ? 3'd0 : 3'd4;
							pwdata <= it.data;
							apb_ph = 1;
						end
					end else if (!it.drain || quiet >= 4) begin
						void'(pend_q.pop_front());
						cur = it;
						command <= it.cmd;
						source_node <= it.src;
						target_node <= it.tgt;
						last_edge <= it.last;
						read_index <= it.idx;
						go = 1'b1;
						gap = draw_gap();
					end
				end
			end
			start <= go;
		end
	end

	// monitor
	always @(posedge clk) begin : watch
		beat_t w;
		if (arst_n && done) begin
			n_beats++;
			if (csr_expect_q.size() == 0) begin
				report("unexpected beat value", read_value, '0);
			end else begin
				w = csr_expect_q.pop_front();
				if (read_value !== w.value) report("read_value", read_value, w.value);
				if (status !== w.st) report("status", {11'b0, status}, {11'b0, w.st});
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("timeout with %0d beats outstanding", csr_expect_q.size());
			$display("tb failed");
			$finish;
		end
	end

	// stimulus
	function automatic void add_cmd(logic [1:0] c, int s, int t, bit l, int i, bit dr = 0);
		item_t it;
		it.is_cfg = 0;
		it.drain = dr;
		it.cmd = c;
		it.src = s;
		it.tgt = t;
		it.last = l;
		it.idx = i;
		it.reg_sel = cab_pkg::REG_MODE;
		it.data = '0;
		pend_q.push_back(it);
	endfunction

	function automatic void add_cfg(logic r, logic [31:0] d);
		item_t it;
		it = '{default: '0};
		it.is_cfg = 1;
		it.reg_sel = r;
		it.data = d;
		pend_q.push_back(it);
	endfunction

	initial begin : stim
		int nc, lim, k, m, n_rand, s, t;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		add_cmd(cab_pkg::CMD_RD_OFS, 0, 0, 0, 0);
		add_cmd(cab_pkg::CMD_RD_NBR, 0, 0, 0, 8191);
		add_cmd(CMD_UNKNOWN, 1023, 1023, 1, 8191);
		add_cmd(cab_pkg::CMD_LOAD, 0, 1023, 0, 0);
		add_cmd(cab_pkg::CMD_LOAD, 1023, 0, 0, 8191);
		add_cmd(cab_pkg::CMD_LOAD, 7, 7, 0, 0);
		add_cmd(cab_pkg::CMD_LOAD, 1023, 1023, 1, 0);
		add_cmd(cab_pkg::CMD_RD_OFS, 0, 0, 0, 0);
		add_cmd(cab_pkg::CMD_RD_OFS, 0, 0, 0, 1024);
		add_cmd(cab_pkg::CMD_RD_OFS, 0, 0, 0, 1025);
		add_cmd(cab_pkg::CMD_RD_NBR, 0, 0, 0, 0);
		add_cmd(cab_pkg::CMD_RD_NBR, 0, 0, 0, 7);
		add_cmd(cab_pkg::CMD_RD_NBR, 0, 0, 0, 8);
		add_cmd(CMD_UNKNOWN, 0, 0, 0, 0);
		add_cfg(cab_pkg::REG_MODE, 32'd1);
		add_cfg(cab_pkg::REG_NODES, 32'd3);
		add_cmd(cab_pkg::CMD_LOAD, 2, 1, 0, 0);
		add_cmd(cab_pkg::CMD_LOAD, 3, 0, 0, 0);
		add_cmd(cab_pkg::CMD_LOAD, 0, 1023, 1, 0);
		add_cmd(cab_pkg::CMD_RD_OFS, 0, 0, 0, 3);
		add_cmd(cab_pkg::CMD_RD_NBR, 0, 0, 0, 0);
		add_cfg(cab_pkg::REG_NODES, 32'd1024);
		add_cmd(cab_pkg::CMD_RD_OFS, 0, 0, 0, 4);
		add_cfg(cab_pkg::REG_NODES, 32'd0);
		add_cmd(cab_pkg::CMD_LOAD, 0, 0, 1, 0);
		add_cmd(cab_pkg::CMD_RD_OFS, 0, 0, 0, 0);
		add_cmd(cab_pkg::CMD_RD_NBR, 0, 0, 0, 0);
		add_cfg(cab_pkg::REG_NODES, 32'd2047);
		add_cmd(cab_pkg::CMD_RD_OFS, 0, 0, 0, 1);

		n_rand = 0;
		while (n_rand < 1850) begin
			if ($urandom_range(0, 2) == 0) add_cfg(cab_pkg::REG_MODE, $urandom);
			case ($urandom_range(0, 7))
				0: nc = 1;
				1: nc = 2;
				2: nc = 1024;
				3: nc = $urandom_range(1025, 2047);
				default: nc = $urandom_range(1, 40);
			endcase
			add_cfg(cab_pkg::REG_NODES, {$urandom_range(0, 2 ** 21 - 1), nc[10:0]});
			lim = nc > 1024 ? 1024 : nc;
			if (n_rand > 900 && n_rand < 1000) begin
				// fill the edge store, then one more edge bounces and builds
				for (int i = 0; i < cab_pkg::MAX_EDGES; i++)
					add_cmd(cab_pkg::CMD_LOAD, $urandom_range(0, lim - 1),
						$urandom_range(0, lim - 1), 0, $urandom);
				add_cmd(cab_pkg::CMD_LOAD, 0, 0, 1, 0);
				add_cmd(cab_pkg::CMD_RD_NBR, 0, 0, 0, 8191);
				add_cmd(cab_pkg::CMD_RD_NBR, 0, 0, 0, 4095);
				add_cmd(cab_pkg::CMD_RD_OFS, 0, 0, 0, lim);
				n_rand = 1000;
			end
			k = $urandom_range(0, 9) == 0 ? $urandom_range(0, 3) : $urandom_range(1, 30);
			for (int i = 0; i < k; i++) begin
				if ($urandom_range(0, 9) == 0) begin
					s = $urandom_range(0, 1023);
					t = $urandom_range(0, 1023);
				end else begin
					s = $urandom_range(0, lim - 1);
					t = $urandom_range(0, lim - 1);
				end
				add_cmd(cab_pkg::CMD_LOAD, s, t,
					(i == k - 1) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 40) == 0),
					$urandom);
				n_rand++;
			end
			m = $urandom_range(2, 20);
			for (int i = 0; i < m; i++) begin
				case ($urandom_range(0, 9))
					0: add_cmd(CMD_UNKNOWN, $urandom, $urandom, $urandom, $urandom);
					1: add_cmd($urandom_range(1, 2), 0, 0, 0, $urandom, $urandom_range(0, 9) == 0);
					2, 3, 4: add_cmd(cab_pkg::CMD_RD_OFS, $urandom, $urandom, $urandom,
						$urandom_range(0, lim + 1));
					default: add_cmd(cab_pkg::CMD_RD_NBR, $urandom, $urandom, $urandom,
						$urandom_range(0, 2 * k + 1));
				endcase
				n_rand++;
			end
		end

		// settle on falling edges so driver updates have landed
		do @(negedge clk);
		while (pend_q.size() != 0 || start || apb_ph != 0 || csr_expect_q.size() != 0 ||
			busy);
		repeat (20) @(posedge clk);
		$display("covered %0d loads, %0d reads, %0d builds, %0d result beats checked",
			n_loads, n_reads, n_builds, n_beats);
		if (errors == 0 && csr_expect_q.size() == 0) begin
			$display("tb passed");
		end else begin
			$display("%0d mismatches, %0d beats missing", errors, csr_expect_q.size());
			$display("tb failed");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/cab_pkg.sv
rtl/cab_ram.sv
rtl/cab_seq.sv
rtl/csr_adjacency_build.sv
tb/tb.sv
